// ===== rtl/core/lpg_pkg.sv =====
`timescale 1ns / 1ps

package lpg_pkg;

   // most points produced for one request transaction
   localparam int SLICE_LEN   = 64;
   localparam int SLICE_CNT_W = $clog2(SLICE_LEN);

   // request payload
   typedef struct packed {
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
      logic signed [15:0] end_x;
      logic signed [15:0] end_y;
      logic        [15:0] max_points;
   } req_type;

   // response payload
   typedef struct packed {
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic               last_point;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;   // latch a new line
      logic emit;   // register the current point and step
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last;   // current point ends the run
   } status_type;

endpackage

// ===== rtl/core/lpg_datapath.sv =====
`timescale 1ns / 1ps

module lpg_datapath import lpg_pkg::*; #(
   parameter int COORD_WIDTH = 16
) (
   input  logic       clock,
   input  req_type    req_payload,
   input  cmd_type    cmd,
   output status_type status,
   output rsp_type    rsp_payload
);

   localparam int W  = COORD_WIDTH;
   localparam int IW = (W > 16) ? W : 16;
   localparam int EW = W + 3;

   // run registers
   logic signed [W-1:0]  cur_x_ff, cur_y_ff, target_x_ff, target_y_ff;
   logic signed [EW-1:0] span_x_ff, neg_span_y_ff, error_ff;
   logic                 step_x_neg_ff, step_y_neg_ff;
   logic [15:0]          points_ff, limit_ff;
   rsp_type              rsp_ff;

   // request fields taken as low W bits of the zero-extended field
   logic [IW-1:0]       sx_ext, sy_ext, ex_ext, ey_ext;
   logic signed [W-1:0] sx, sy, ex, ey;
   logic signed [W:0]   dx_d, dy_d, dx_abs, dy_abs;

   assign sx_ext = IW'($unsigned(req_payload.start_x));
   assign sy_ext = IW'($unsigned(req_payload.start_y));
   assign ex_ext = IW'($unsigned(req_payload.end_x));
   assign ey_ext = IW'($unsigned(req_payload.end_y));
   assign sx = signed'(sx_ext[W-1:0]);
   assign sy = signed'(sy_ext[W-1:0]);
   assign ex = signed'(ex_ext[W-1:0]);
   assign ey = signed'(ey_ext[W-1:0]);

   // spans of the new line
   assign dx_d   = (W+1)'(ex) - (W+1)'(sx);
   assign dy_d   = (W+1)'(ey) - (W+1)'(sy);
   assign dx_abs = dx_d[W] ? -dx_d : dx_d;
   assign dy_abs = dy_d[W] ? -dy_d : dy_d;

   logic signed [EW-1:0] span_x_in, neg_span_y_in;
   assign span_x_in     = EW'(dx_abs);
   assign neg_span_y_in = -EW'(dy_abs);

   // end of run test on the current point
   logic [15:0] points_in;
   logic        last;
   assign points_in = points_ff + 16'd1;
   assign last = ((limit_ff != '0) && (points_in >= limit_ff)) ||
                 ((cur_x_ff == target_x_ff) && (cur_y_ff == target_y_ff));
   assign status.last = last;

   // bresenham step
   logic signed [EW:0]   e2;
   logic                 move_x, move_y;
   logic signed [EW-1:0] error_in;
   assign e2     = {error_ff, 1'b0};
   assign move_x = e2 >= (EW+1)'(neg_span_y_ff);
   assign move_y = e2 <= (EW+1)'(span_x_ff);
   assign error_in = error_ff + (move_x ? neg_span_y_ff : '0)
                              + (move_y ? span_x_ff : '0);

   logic signed [W-1:0] cur_x_in, cur_y_in;
   assign cur_x_in = cur_x_ff + (step_x_neg_ff ? {W{1'b1}} : W'(1));
   assign cur_y_in = cur_y_ff + (step_y_neg_ff ? {W{1'b1}} : W'(1));

   // output coordinates as low W bits, zero-extended into the field
   logic [IW-1:0] px_ext, py_ext;
   assign px_ext = IW'($unsigned(cur_x_ff));
   assign py_ext = IW'($unsigned(cur_y_ff));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_x_ff      <= sx;
         cur_y_ff      <= sy;
         target_x_ff   <= ex;
         target_y_ff   <= ey;
         limit_ff      <= req_payload.max_points;
         span_x_ff     <= span_x_in;
         neg_span_y_ff <= neg_span_y_in;
         step_x_neg_ff <= !(sx < ex);
         step_y_neg_ff <= !(sy < ey);
         error_ff      <= span_x_in + neg_span_y_in;
         points_ff     <= '0;
      end else if (cmd.emit) begin
         points_ff          <= points_in;
         rsp_ff.point_x     <= px_ext[15:0];
         rsp_ff.point_y     <= py_ext[15:0];
         rsp_ff.last_point  <= last;
         if (!last) begin
            error_ff <= error_in;
            if (move_x) begin
               cur_x_ff <= cur_x_in;
            end
            if (move_y) begin
               cur_y_ff <= cur_y_in;
            end
         end
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/core/lpg_ctrl.sv =====
`timescale 1ns / 1ps

module lpg_ctrl import lpg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic {
      IDLE,
      RUN
   } state_type;

   state_type              state_ff, state_in;
   logic                   run_active_ff, run_active_in;
   logic [SLICE_CNT_W-1:0] slice_ff, slice_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   accept, emit;

   // handshakes
   assign req_stall = (state_ff != IDLE);
   assign accept    = req_valid && (state_ff == IDLE);
   assign emit      = (state_ff == RUN) && (!rsp_valid_ff || !rsp_stall);

   assign cmd.load = accept && !run_active_ff;
   assign cmd.emit = emit;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in      = state_ff;
      run_active_in = run_active_ff;
      slice_in      = slice_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               state_in      = RUN;
               run_active_in = 1'b1;
               slice_in      = '0;
            end
         end
         RUN: begin
            if (emit) begin
               slice_in = slice_ff + SLICE_CNT_W'(1);
               if (status.last) begin
                  run_active_in = 1'b0;
                  state_in      = IDLE;
               end else if (slice_ff == SLICE_CNT_W'(SLICE_LEN - 1)) begin
                  state_in = IDLE;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         run_active_ff <= 1'b0;
         slice_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         run_active_ff <= run_active_in;
         slice_ff      <= slice_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // a transaction always starts a slice
   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == RUN))
      else $error("accepted transaction did not start a slice");

   // the last point of a run ends the run
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (emit && status.last) |=> (!run_active_ff && state_ff == IDLE))
      else $error("run still active after last point");

   // a response only appears after a point was registered
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(emit))
      else $error("response valid without a registered point");

   // a fresh line is only loaded when no run is pending
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!run_active_ff && state_ff == IDLE))
      else $error("line loaded during a run");

endmodule

// ===== rtl/core/line_point_generator.sv =====
`timescale 1ns / 1ps

// Bresenham line point generator, all octants.
// req channel: one transaction carries start and end points and a point
// limit (0 = no limit). When no run is pending it starts a new line;
// when a run is still pending its fields are ignored and it continues
// that run.
// rsp channel: one transaction per grid point, starting at the start
// point; last_point marks the end point or the point that hits the limit.
// Each request transaction yields 1 to 64 points, so a line of N points
// needs ceil(N / 64) request transactions.
// After a request is accepted the controller enters RUN, where the first
// point is registered into rsp_payload together with rsp_valid.
// Throughput: one point per cycle while rsp is not stalled, set by the
// single error-term update loop; the next request is taken the cycle
// after the slice's final point is registered.
// A stall on rsp holds the registered point and freezes the walk.
// Reset clears the controller: no run is pending and rsp_valid is low.
module line_point_generator import lpg_pkg::*; #(
   parameter int COORD_WIDTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   cmd_type    cmd;
   status_type status;

   lpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lpg_datapath #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import lpg_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_LINES = 95;
   localparam int LONG_HOLD    = 300;
   localparam int PRINT_CAP    = 30;

   // expected grid points of the line being walked, one slice per request
   class line_scoreboard;
      rsp_type            expected_points[$];
      logic signed [15:0] cur_x, cur_y, target_x, target_y;
      logic        [16:0] span_x;
      logic signed [17:0] neg_span_y;
      logic signed [18:0] err;
      logic               step_x_neg, step_y_neg;
      logic        [15:0] points_sent, limit;
      bit                 run_pending;
      int                 mismatches, points_checked, requests, lines;

      function new();
         cur_x = '0; cur_y = '0; target_x = '0; target_y = '0;
         span_x = '0; neg_span_y = '0; err = '0;
         step_x_neg = 1'b0; step_y_neg = 1'b0;
         points_sent = '0; limit = '0;
         run_pending = 1'b0;
         mismatches = 0; points_checked = 0; requests = 0; lines = 0;
      endfunction

      // accepted request transaction: queue the points of the next slice
      function void note_request(req_type r);
         logic        [16:0] span_y;
         logic signed [19:0] e2;
         logic               last;
         rsp_type            p;
         int                 n;
         requests++;
         if (!run_pending) begin
            lines++;
            cur_x = r.start_x;
            cur_y = r.start_y;
            target_x = r.end_x;
            target_y = r.end_y;
            limit = r.max_points;
            span_x = (target_x >= cur_x) ? {target_x[15], target_x} - {cur_x[15], cur_x}
                                         : {cur_x[15], cur_x} - {target_x[15], target_x};
            span_y = (target_y >= cur_y) ? {target_y[15], target_y} - {cur_y[15], cur_y}
                                         : {cur_y[15], cur_y} - {target_y[15], target_y};
            neg_span_y = -$signed({1'b0, span_y});
            step_x_neg = !(cur_x < target_x);
            step_y_neg = !(cur_y < target_y);
            err = $signed({2'b00, span_x}) + neg_span_y;
            points_sent = '0;
            run_pending = 1'b1;
         end
         n = 0;
         while (run_pending && n < SLICE_LEN) begin
            p.point_x = cur_x;
            p.point_y = cur_y;
            points_sent = points_sent + 16'd1;
            last = (limit != 0 && points_sent >= limit) ||
                   (cur_x == target_x && cur_y == target_y);
            p.last_point = last;
            expected_points = {expected_points, p};
            n++;
            if (last) begin
               run_pending = 1'b0;
            end else begin
               // error-term step, both tests use the error before update
               e2 = {err, 1'b0};
               if (e2 >= neg_span_y) begin
                  err = err + neg_span_y;
                  cur_x = step_x_neg ? cur_x - 16'sd1 : cur_x + 16'sd1;
               end
               if (e2 <= $signed({1'b0, span_x})) begin
                  err = err + $signed({2'b00, span_x});
                  cur_y = step_y_neg ? cur_y - 16'sd1 : cur_y + 16'sd1;
               end
            end
         end
      endfunction

      task report_mismatch(string msg);
         if (mismatches < PRINT_CAP)
            $display("tb: mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      // accepted response transaction against the oldest expected point
      task check_point(rsp_type got);
         rsp_type want;
         if (expected_points.size() == 0) begin
            report_mismatch($sformatf("point (%0d, %0d) with nothing expected",
                                      got.point_x, got.point_y));
            return;
         end
         want = expected_points.pop_front();
         if (got.point_x !== want.point_x)
            report_mismatch($sformatf("point %0d x got %0d want %0d",
                                      points_checked, got.point_x, want.point_x));
         if (got.point_y !== want.point_y)
            report_mismatch($sformatf("point %0d y got %0d want %0d",
                                      points_checked, got.point_y, want.point_y));
         if (got.last_point !== want.last_point)
            report_mismatch($sformatf("point %0d last got %b want %b",
                                      points_checked, got.last_point, want.last_point));
         points_checked++;
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   line_scoreboard sb = new();

   int tx_idle_pct = 11;
   int rx_idle_pct = 51;
   int hold_request = 0;
   int hold_left = 0;
   int cycle_count = 0;

   line_point_generator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_point(rsp_payload);
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // offer one request transaction and hold it until accepted
   task automatic drive_request(input req_type r);
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic sender_gap();
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // fields of a continuation transaction are ignored by the block
   function automatic req_type noise_request();
      return 80'({$urandom(), $urandom(), $urandom()});
   endfunction

   // send a line, then continuation transactions until its run is done
   task automatic run_line(input req_type r);
      drive_request(r);
      sender_gap();
      while (sb.run_pending) begin
         drive_request(noise_request());
         sender_gap();
      end
   endtask

   function automatic req_type make_line(input logic signed [15:0] sx, sy, ex, ey,
                                         input logic [15:0] lim);
      req_type r;
      r.start_x = sx;
      r.start_y = sy;
      r.end_x = ex;
      r.end_y = ey;
      r.max_points = lim;
      return r;
   endfunction

   // coordinate within reach of base, folded back instead of wrapping
   function automatic logic signed [15:0] offset_coord(input logic signed [15:0] base,
                                                       input int reach);
      int off;
      int c;
      off = $urandom_range(2 * reach);
      c = base + off - reach;
      if (c > 32767 || c < -32768)
         c = base - (off - reach);
      return 16'(c);
   endfunction

   function automatic req_type random_line();
      req_type r;
      int      kind;
      int      reach;
      kind = $urandom_range(99);
      r.start_x = 16'($urandom());
      r.start_y = 16'($urandom());
      r.max_points = '0;
      if (kind < 10) begin
         // anywhere on the grid, cut short by the limit
         r.end_x = 16'($urandom());
         r.end_y = 16'($urandom());
         r.max_points = 16'($urandom_range(1, 50));
      end else if (kind < 15) begin
         // single point
         r.end_x = r.start_x;
         r.end_y = r.start_y;
         r.max_points = 16'($urandom());
      end else begin
         reach = (kind < 88) ? 24 : 150;
         r.end_x = offset_coord(r.start_x, $urandom_range(reach));
         r.end_y = offset_coord(r.start_y, $urandom_range(reach));
         case ($urandom_range(3))
            0: r.max_points = 16'($urandom_range(1, 2 * reach));
            1: r.max_points = 16'($urandom());
            default: r.max_points = '0;
         endcase
      end
      return r;
   endfunction

   initial begin
      int phase;
      int n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed lines: every octant, axis moves, limits, extremes
      run_line(make_line(0, 0, 0, 0, 0));
      run_line(make_line(-5, 3, 5, 3, 0));
      run_line(make_line(5, -3, -5, -3, 0));
      run_line(make_line(2, -6, 2, 6, 0));
      run_line(make_line(2, 6, 2, -6, 0));
      run_line(make_line(0, 0, 7, 3, 0));
      run_line(make_line(0, 0, 3, 7, 0));
      run_line(make_line(0, 0, -3, 7, 0));
      run_line(make_line(0, 0, -7, 3, 0));
      run_line(make_line(0, 0, -7, -3, 0));
      run_line(make_line(0, 0, -3, -7, 0));
      run_line(make_line(0, 0, 3, -7, 0));
      run_line(make_line(0, 0, 7, -3, 0));
      run_line(make_line(0, 0, 5, 5, 0));
      run_line(make_line(0, 0, -5, -5, 0));
      run_line(make_line(0, 0, 4, 0, 5));
      run_line(make_line(1, 1, 9, 4, 1));
      run_line(make_line(-32768, -32768, 32767, 32767, 70));
      run_line(make_line(32767, -32768, -32768, 32767, 3));
      run_line(make_line(-32768, 32767, 32767, -32768, 66));
      run_line(make_line(10, 10, 73, 20, 0));
      run_line(make_line(-10, 0, 54, 1, 0));
      run_line(make_line(0, 0, -130, -40, 0));
      run_line(make_line(100, -200, 103, -198, 16'hffff));

      // random lines under three idle patterns
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin tx_idle_pct = 11; rx_idle_pct = 51; end
            1: begin tx_idle_pct = 51; rx_idle_pct = 11; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         // receiver holds off while the sender keeps pushing
         if (phase == 0)
            hold_request = LONG_HOLD;
         for (n = 0; n < RANDOM_LINES; n++) begin
            run_line(random_line());
            if (phase == 1 && n == RANDOM_LINES / 2) begin
               req_valid <= 1'b0;
               while (sb.expected_points.size() != 0) @(posedge clock);
            end
         end
      end

      req_valid <= 1'b0;
      while (sb.expected_points.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("tb: %0d lines in %0d request transactions, %0d points checked",
               sb.lines, sb.requests, sb.points_checked);
      $display("tb: all octants, axis moves, limits, coordinate extremes, long hold-off");
      if (sb.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/lpg_pkg.sv
rtl/core/lpg_datapath.sv
rtl/core/lpg_ctrl.sv
rtl/core/line_point_generator.sv
sim/tb.sv
